[rtl/core/multiplexed_servo_pulse_sequencer_macros.svh]
// ---------------------------------------------------------------------------
// Servo pulse sequencer assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MULTIPLEXED_SERVO_PULSE_SEQUENCER_MACROS_SVH
`define MULTIPLEXED_SERVO_PULSE_SEQUENCER_MACROS_SVH

// check that a condition holds at every edge out of reset
`define MPSS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// check that a trigger is followed by a consequent sequence
`define MPSS_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

`endif

[rtl/core/mpss_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo pulse sequencer package
// Field widths, action and register codes, constants and shared types.
// ---------------------------------------------------------------------------
package mpss_pkg;

	localparam int ACT_W     = 3;
	localparam int SLOT_W    = 4;
	localparam int PIN_W     = 8;
	localparam int TICK_W    = 16;
	localparam int CUR_W     = 5;
	localparam int ELAPSED_W = 20;
	localparam int DEG_W     = 8;
	localparam int CFG_IDX_W = 4;
	localparam int RECIP_W   = 25;
	localparam int DEG_SHIFT = 32;

	localparam logic [ACT_W-1:0] ACT_ATTACH    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DETACH    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET_PULSE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SET_DEG   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_OVERFLOW  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_DEF_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME   = 4'd3;

	localparam logic [TICK_W-1:0] RST_DEF_MIN = 16'd544;
	localparam logic [TICK_W-1:0] RST_DEF_MAX = 16'd2400;
	localparam logic [TICK_W-1:0] RST_CENTER  = 16'd1500;
	localparam logic [TICK_W-1:0] RST_FRAME   = 16'd20000;

	localparam logic [CUR_W-1:0]  CURSOR_START     = 5'd31;
	localparam logic [TICK_W-1:0] EMPTY_SLOT_TICKS = 16'd100;
	localparam logic [TICK_W-1:0] END_MARGIN       = 16'd4;
	localparam logic [DEG_W-1:0]  MAX_DEGREES      = 8'd180;

	// floor(2^DEG_SHIFT / 180), low by at most one quotient step
	localparam logic [RECIP_W-1:0] DEG_RECIP =
		RECIP_W'((64'd1 << DEG_SHIFT) / 64'(MAX_DEGREES));

	typedef struct packed {
		logic [PIN_W-1:0]  pin;
		logic [TICK_W-1:0] lo;
		logic [TICK_W-1:0] hi;
		logic [TICK_W-1:0] pulse;
	} slot_entry_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [SLOT_W-1:0] slot;
		logic [PIN_W-1:0]  pin_id;
		logic [TICK_W-1:0] min_ticks;
		logic [TICK_W-1:0] max_ticks;
		logic [TICK_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] slot_out;
		logic              lower_valid;
		logic [PIN_W-1:0]  lower_pin;
		logic              raise_valid;
		logic [PIN_W-1:0]  raise_pin;
		logic              reload_valid;
		logic [TICK_W-1:0] reload_ticks;
		logic              frame_restart;
	} rsp_t;

	typedef struct packed {
		logic [TICK_W-1:0] lo;
		logic [TICK_W-1:0] hi;
		logic [DEG_W-1:0]  deg;
	} deg_req_t;

endpackage

[rtl/core/mpss_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo pulse sequencer channels
// Command, result and configuration write channels with valid and ready.
// ---------------------------------------------------------------------------
interface mpss_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [mpss_pkg::ACT_W-1:0]      action;
	logic [mpss_pkg::SLOT_W-1:0]     slot;
	logic [mpss_pkg::PIN_W-1:0]      pin_id;
	logic [mpss_pkg::TICK_W-1:0]     min_ticks;
	logic [mpss_pkg::TICK_W-1:0]     max_ticks;
	logic [mpss_pkg::TICK_W-1:0]     value;

	modport source (output valid, action, slot, pin_id, min_ticks, max_ticks, value,
		input ready);
	modport sink (input valid, action, slot, pin_id, min_ticks, max_ticks, value,
		output ready);
endinterface

interface mpss_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            status;
	logic [mpss_pkg::SLOT_W-1:0]     slot_out;
	logic                            lower_valid;
	logic [mpss_pkg::PIN_W-1:0]      lower_pin;
	logic                            raise_valid;
	logic [mpss_pkg::PIN_W-1:0]      raise_pin;
	logic                            reload_valid;
	logic [mpss_pkg::TICK_W-1:0]     reload_ticks;
	logic                            frame_restart;

	modport source (output valid, status, slot_out, lower_valid, lower_pin, raise_valid,
		raise_pin, reload_valid, reload_ticks, frame_restart, input ready);
	modport sink (input valid, status, slot_out, lower_valid, lower_pin, raise_valid,
		raise_pin, reload_valid, reload_ticks, frame_restart, output ready);
endinterface

interface mpss_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mpss_pkg::CFG_IDX_W-1:0]  index;
	logic [mpss_pkg::TICK_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/mpss_deg_scale.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo pulse sequencer degree scaler
// Three-stage pipe: lo + floor((hi - lo) * deg / 180), or lo when hi < lo.
// ---------------------------------------------------------------------------
module mpss_deg_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  mpss_pkg::deg_req_t          req,
	output logic                        done,
	output logic [mpss_pkg::TICK_W-1:0] result
);

	localparam int PROD_W = mpss_pkg::TICK_W + mpss_pkg::DEG_W;
	localparam int MUL_W  = PROD_W + mpss_pkg::RECIP_W;

	logic                        v_s1, v_s2, done_q;
	logic [PROD_W-1:0]           prod_s1, prod_s2;
	logic [mpss_pkg::TICK_W-1:0] lo_s1, lo_s2, q0_s2, result_q;
	logic                        ge_s1, ge_s2;

	logic [mpss_pkg::TICK_W-1:0] diff;
	logic [MUL_W-1:0]            recip_prod;
	logic [PROD_W-1:0]           back, rem;
	logic [mpss_pkg::TICK_W-1:0] quot;
	logic [mpss_pkg::TICK_W:0]   sum;

	assign diff       = req.hi - req.lo;
	assign recip_prod = MUL_W'(prod_s1) * MUL_W'(mpss_pkg::DEG_RECIP);
	assign back       = PROD_W'(q0_s2) * PROD_W'(mpss_pkg::MAX_DEGREES);
	assign rem        = prod_s2 - back;
	assign quot       = q0_s2 + mpss_pkg::TICK_W'(rem >= PROD_W'(mpss_pkg::MAX_DEGREES));
	assign sum        = {1'b0, lo_s2} + {1'b0, quot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(diff) * PROD_W'(req.deg);
		lo_s1    <= req.lo;
		ge_s1    <= req.hi >= req.lo;
		prod_s2  <= prod_s1;
		q0_s2    <= recip_prod[mpss_pkg::DEG_SHIFT +: mpss_pkg::TICK_W];
		lo_s2    <= lo_s1;
		ge_s2    <= ge_s1;
		result_q <= ge_s2 ? sum[mpss_pkg::TICK_W-1:0] : lo_s2;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/core/multiplexed_servo_pulse_sequencer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multiplexed servo pulse sequencer
// Slot table of servo pins and pulses, stepped one timer overflow at a time.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one action per transfer (attach, detach, set pulse, set
//   degrees, timer overflow); rsp returns exactly one result per action.
//   cfg writes the four setup registers; it is always ready. The user must
//   write it only while no action is in flight; the block does not enforce it.
//   One action is worked at a time. The slot table sits in one synchronous
//   RAM with a registered read; set pulse and set degrees read, modify and
//   write back an entry. Set degrees runs through the three-stage degree
//   scaler, overflow makes up to two table reads, and attach makes one table
//   read per slot scanned for the pin.
//   A new action is taken once the state is back to idle after the result
//   is handed to the output register.
//   Reset clears the in-use bits, the slot count and the frame position and
//   loads the register defaults; the table RAM is not cleared.
//   The output register holds a result while rsp is stalled; the next
//   action is still accepted and waits at its end until the register frees.
// ---------------------------------------------------------------------------
`include "multiplexed_servo_pulse_sequencer_macros.svh"

module multiplexed_servo_pulse_sequencer #(
	parameter int SLOTS = 12
) (
	input logic     clk,
	input logic     arst_n,
	mpss_cmd_if.sink   cmd,
	mpss_rsp_if.source rsp,
	mpss_cfg_if.sink   cfg
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [mpss_pkg::CUR_W-1:0] SLOTS_N = mpss_pkg::CUR_W'(SLOTS);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_DECODE    = 9'b000000010,
		S_ATT_SCAN  = 9'b000000100,
		S_SET_RD    = 9'b000001000,
		S_DEG_WAIT  = 9'b000010000,
		S_OVF_LOW   = 9'b000100000,
		S_OVF_STEP  = 9'b001000000,
		S_OVF_RAISE = 9'b010000000,
		S_DONE      = 9'b100000000
	} state_t;

	state_t                          state_q;
	mpss_pkg::cmd_t                  cmd_q;
	mpss_pkg::rsp_t                  res_q, out_q;
	logic                            out_valid_q;
	logic [mpss_pkg::TICK_W-1:0]     def_min_q, def_max_q, center_q, period_q;
	logic [SLOTS-1:0]                used_q;
	logic [mpss_pkg::CUR_W-1:0]      taken_q, cursor_q, next_q;
	logic [mpss_pkg::ELAPSED_W-1:0]  elapsed_q;
	logic [IDX_W-1:0]                scan_q;

	mpss_pkg::slot_entry_t           slot_mem [SLOTS];
	mpss_pkg::slot_entry_t           rd_q;
	logic                            rd_en, we;
	logic [IDX_W-1:0]                rd_addr, wr_addr;
	mpss_pkg::slot_entry_t           wr_data, new_entry;

	logic                            deg_start, deg_done;
	mpss_pkg::deg_req_t              deg_req;
	logic [mpss_pkg::TICK_W-1:0]     deg_value;

	logic                            cmd_fire, out_load;
	logic [IDX_W-1:0]                slot_idx, taken_idx, next_idx, cursor_idx;
	logic                            slot_ok, is_full, scan_hit, scan_more;
	logic                            step_go, next_used, cur_used, end_fits;
	logic [mpss_pkg::CUR_W-1:0]      scan_nxt;
	logic [mpss_pkg::ELAPSED_W:0]    end_sum;
	logic [mpss_pkg::ELAPSED_W-1:0]  end_left;

	function automatic logic [mpss_pkg::TICK_W-1:0] clamp_pulse(
		mpss_pkg::slot_entry_t e, logic [mpss_pkg::TICK_W-1:0] v);
		logic [mpss_pkg::TICK_W-1:0] t;
		t = (v < e.lo) ? e.lo : v;
		return (t > e.hi) ? e.hi : t;
	endfunction

	assign cmd_fire   = cmd.valid && cmd.ready;
	assign cmd.ready  = state_q == S_IDLE;
	assign cfg.ready  = 1'b1;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign slot_idx   = cmd_q.slot[IDX_W-1:0];
	assign taken_idx  = taken_q[IDX_W-1:0];
	assign next_idx   = next_q[IDX_W-1:0];
	assign cursor_idx = cursor_q[IDX_W-1:0];
	assign slot_ok    = (mpss_pkg::CUR_W'(cmd_q.slot) < SLOTS_N) && used_q[slot_idx];
	assign is_full    = taken_q >= SLOTS_N;
	assign scan_hit   = used_q[scan_q] && (rd_q.pin == cmd_q.pin_id);
	assign scan_nxt   = mpss_pkg::CUR_W'(scan_q) + mpss_pkg::CUR_W'(1);
	assign scan_more  = scan_nxt < taken_q;
	assign step_go    = (taken_q != '0) && (next_q < SLOTS_N);
	assign next_used  = used_q[next_idx];
	assign cur_used   = (cursor_q < SLOTS_N) && used_q[cursor_idx];
	assign end_sum    = {1'b0, elapsed_q} + (mpss_pkg::ELAPSED_W + 1)'(mpss_pkg::END_MARGIN);
	assign end_fits   = end_sum < (mpss_pkg::ELAPSED_W + 1)'(period_q);
	assign end_left   = mpss_pkg::ELAPSED_W'(period_q) - elapsed_q;

	always_comb begin
		new_entry.pin   = cmd_q.pin_id;
		new_entry.lo    = (cmd_q.min_ticks != '0) ? cmd_q.min_ticks : def_min_q;
		new_entry.hi    = (cmd_q.max_ticks != '0) ? cmd_q.max_ticks : def_max_q;
		new_entry.pulse = center_q;
	end

	always_comb begin
		deg_req.lo  = rd_q.lo;
		deg_req.hi  = rd_q.hi;
		deg_req.deg = (cmd_q.value > mpss_pkg::TICK_W'(mpss_pkg::MAX_DEGREES)) ?
			mpss_pkg::MAX_DEGREES : cmd_q.value[mpss_pkg::DEG_W-1:0];
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		we        = 1'b0;
		wr_addr   = slot_idx;
		wr_data   = rd_q;
		deg_start = 1'b0;
		case (state_q)
			S_DECODE: begin
				case (cmd_q.action)
					mpss_pkg::ACT_ATTACH: begin
						if (!is_full && taken_q == '0) begin
							we      = 1'b1;
							wr_addr = taken_idx;
							wr_data = new_entry;
						end else if (!is_full) begin
							rd_en = 1'b1;
						end
					end
					mpss_pkg::ACT_SET_PULSE, mpss_pkg::ACT_SET_DEG: begin
						rd_en   = slot_ok;
						rd_addr = slot_idx;
					end
					mpss_pkg::ACT_OVERFLOW: begin
						rd_en   = (cursor_q != mpss_pkg::CURSOR_START) && cur_used;
						rd_addr = cursor_idx;
					end
					default: ;
				endcase
			end
			S_ATT_SCAN: begin
				if (!scan_hit && scan_more) begin
					rd_en   = 1'b1;
					rd_addr = scan_nxt[IDX_W-1:0];
				end else if (!scan_hit) begin
					we      = 1'b1;
					wr_addr = taken_idx;
					wr_data = new_entry;
				end
			end
			S_SET_RD: begin
				if (cmd_q.action == mpss_pkg::ACT_SET_PULSE) begin
					we            = 1'b1;
					wr_data.pulse = clamp_pulse(rd_q, cmd_q.value);
				end else begin
					deg_start = 1'b1;
				end
			end
			S_DEG_WAIT: begin
				we            = deg_done;
				wr_data.pulse = clamp_pulse(rd_q, deg_value);
			end
			S_OVF_STEP: begin
				rd_en   = step_go && next_used;
				rd_addr = next_idx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			slot_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= slot_mem[rd_addr];
	end

	mpss_deg_scale u_deg_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (deg_start),
		.req    (deg_req),
		.done   (deg_done),
		.result (deg_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			def_min_q   <= mpss_pkg::RST_DEF_MIN;
			def_max_q   <= mpss_pkg::RST_DEF_MAX;
			center_q    <= mpss_pkg::RST_CENTER;
			period_q    <= mpss_pkg::RST_FRAME;
			used_q      <= '0;
			taken_q     <= '0;
			cursor_q    <= mpss_pkg::CURSOR_START;
			elapsed_q   <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					mpss_pkg::CFG_DEF_MIN: def_min_q <= cfg.data;
					mpss_pkg::CFG_DEF_MAX: def_max_q <= cfg.data;
					mpss_pkg::CFG_CENTER:  center_q  <= cfg.data;
					mpss_pkg::CFG_FRAME:   period_q  <= cfg.data;
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_fire)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					case (cmd_q.action)
						mpss_pkg::ACT_ATTACH: begin
							if (is_full) begin
								state_q <= S_DONE;
							end else if (taken_q == '0) begin
								used_q[taken_idx] <= 1'b1;
								taken_q           <= taken_q + mpss_pkg::CUR_W'(1);
								state_q           <= S_DONE;
							end else begin
								state_q <= S_ATT_SCAN;
							end
						end
						mpss_pkg::ACT_DETACH: begin
							if (slot_ok)
								used_q[slot_idx] <= 1'b0;
							state_q <= S_DONE;
						end
						mpss_pkg::ACT_SET_PULSE, mpss_pkg::ACT_SET_DEG: begin
							state_q <= slot_ok ? S_SET_RD : S_DONE;
						end
						mpss_pkg::ACT_OVERFLOW: begin
							if (cursor_q == mpss_pkg::CURSOR_START) begin
								elapsed_q <= '0;
								state_q   <= S_OVF_STEP;
							end else begin
								state_q <= cur_used ? S_OVF_LOW : S_OVF_STEP;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_ATT_SCAN: begin
					if (scan_hit) begin
						state_q <= S_DONE;
					end else if (!scan_more) begin
						used_q[taken_idx] <= 1'b1;
						taken_q           <= taken_q + mpss_pkg::CUR_W'(1);
						state_q           <= S_DONE;
					end
				end
				S_SET_RD: begin
					state_q <= (cmd_q.action == mpss_pkg::ACT_SET_PULSE) ? S_DONE : S_DEG_WAIT;
				end
				S_DEG_WAIT: begin
					if (deg_done)
						state_q <= S_DONE;
				end
				S_OVF_LOW: state_q <= S_OVF_STEP;
				S_OVF_STEP: begin
					if (step_go && next_used) begin
						state_q <= S_OVF_RAISE;
					end else if (step_go) begin
						elapsed_q <= elapsed_q + mpss_pkg::ELAPSED_W'(mpss_pkg::EMPTY_SLOT_TICKS);
						cursor_q  <= next_q;
						state_q   <= S_DONE;
					end else begin
						cursor_q <= mpss_pkg::CURSOR_START;
						state_q  <= S_DONE;
					end
				end
				S_OVF_RAISE: begin
					elapsed_q <= elapsed_q + mpss_pkg::ELAPSED_W'(rd_q.pulse);
					cursor_q  <= next_q;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q.action    <= cmd.action;
			cmd_q.slot      <= cmd.slot;
			cmd_q.pin_id    <= cmd.pin_id;
			cmd_q.min_ticks <= cmd.min_ticks;
			cmd_q.max_ticks <= cmd.max_ticks;
			cmd_q.value     <= cmd.value;
		end
		if (out_load)
			out_q <= res_q;
		case (state_q)
			S_DECODE: begin
				res_q  <= '0;
				scan_q <= '0;
				next_q <= (cursor_q == mpss_pkg::CURSOR_START) ? '0 :
					cursor_q + mpss_pkg::CUR_W'(1);
				case (cmd_q.action)
					mpss_pkg::ACT_ATTACH: begin
						if (is_full)
							res_q.status <= 1'b1;
					end
					mpss_pkg::ACT_DETACH: begin
						if (!slot_ok)
							res_q.status <= 1'b1;
					end
					default: ;
				endcase
			end
			S_ATT_SCAN: begin
				if (scan_hit)
					res_q.slot_out <= mpss_pkg::SLOT_W'(scan_q);
				else if (scan_more)
					scan_q <= scan_nxt[IDX_W-1:0];
				else
					res_q.slot_out <= taken_q[mpss_pkg::SLOT_W-1:0];
			end
			S_OVF_LOW: begin
				res_q.lower_valid <= 1'b1;
				res_q.lower_pin   <= rd_q.pin;
			end
			S_OVF_STEP: begin
				if (step_go && !next_used) begin
					res_q.reload_valid <= 1'b1;
					res_q.reload_ticks <= mpss_pkg::EMPTY_SLOT_TICKS;
				end else if (!step_go && end_fits) begin
					res_q.reload_valid <= 1'b1;
					res_q.reload_ticks <= end_left[mpss_pkg::TICK_W-1:0];
				end else if (!step_go) begin
					res_q.frame_restart <= 1'b1;
				end
			end
			S_OVF_RAISE: begin
				res_q.raise_valid  <= 1'b1;
				res_q.raise_pin    <= rd_q.pin;
				res_q.reload_valid <= 1'b1;
				res_q.reload_ticks <= rd_q.pulse;
			end
			default: ;
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.slot_out      = out_q.slot_out;
	assign rsp.lower_valid   = out_q.lower_valid;
	assign rsp.lower_pin     = out_q.lower_pin;
	assign rsp.raise_valid   = out_q.raise_valid;
	assign rsp.raise_pin     = out_q.raise_pin;
	assign rsp.reload_valid  = out_q.reload_valid;
	assign rsp.reload_ticks  = out_q.reload_ticks;
	assign rsp.frame_restart = out_q.frame_restart;

	`MPSS_ASSERT_IMPLIES(a_scan_in_range, state_q == S_ATT_SCAN,
		(mpss_pkg::CUR_W'(scan_q) < taken_q), "attach scan beyond taken slots")
	`MPSS_ASSERT_ALWAYS(a_cursor_legal,
		(cursor_q == mpss_pkg::CURSOR_START) || (cursor_q < SLOTS_N),
		"frame cursor outside slot range")
	`MPSS_ASSERT_IMPLIES(a_deg_latency, deg_start, ##3 deg_done,
		"degree scaler result not on time")
	`MPSS_ASSERT_ALWAYS(a_taken_bound, taken_q <= SLOTS_N, "slot count exceeds table size")

endmodule
